>>> rtl/core/stem_mix_dc_block_glue_limiter_defines.svh
// assertion macros for the stem mix output stage
`ifndef STEM_MIX_DC_BLOCK_GLUE_LIMITER_DEFINES_SVH
`define STEM_MIX_DC_BLOCK_GLUE_LIMITER_DEFINES_SVH

// implication checked in the same cycle
`define SMDL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smdl assertion failed");

// implication checked in the next cycle
`define SMDL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smdl assertion failed");

`endif

>>> rtl/core/smdl_pkg.sv
// package: constants, types and helpers of the stem mix output stage
package smdl_pkg;

  localparam int STEMS       = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 5;
  localparam int K_W         = (STEMS > 1) ? $clog2(STEMS) : 1;
  localparam int MIX_W       = SAMPLE_BITS + K_W;
  localparam int Q24_SHIFT   = FRAC - 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] GLUE_THRESHOLD = 32'd10066330;
  localparam logic [31:0] STAGE_GAIN     = 32'd751619277;
  localparam logic [63:0] KNEE_POINT     = 64'd16441672;
  localparam logic [31:0] KNEE_SLOPE     = 32'd644245094;
  localparam logic [63:0] KNEE_NUM       = 64'd16441672 * 64'd3650722202;
  localparam logic [63:0] OUT_LIMIT      = 64'd8 << FRAC;
  localparam logic signed [SAMPLE_BITS-1:0] OUT_LIM_S = SAMPLE_BITS'(64'd8 << FRAC);
  localparam logic signed [65:0] SAT_HI  = 66'sd1 <<< 62;
  localparam logic signed [65:0] SAT_LO  = -(66'sd1 <<< 62);

  localparam logic [2:0] CFG_DC_COEF = 3'd0;
  localparam logic [2:0] CFG_ATTACK  = 3'd1;
  localparam logic [2:0] CFG_RELEASE = 3'd2;
  localparam logic [2:0] CFG_MASTER  = 3'd3;
  localparam logic [2:0] CFG_MULTI   = 3'd4;

  typedef struct packed {
    logic [15:0] dc_coefficient;
    logic [15:0] attack_rate;
    logic [15:0] release_rate;
    logic [15:0] master_gain;
    logic        multichannel_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } item_t;

  function automatic logic [62:0] mag63(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m[62:0];
  endfunction

  function automatic logic signed [63:0] sat62(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[63:0];
  endfunction

endpackage

>>> rtl/core/smdl_in_if.sv
// input stream interface: one stem item
interface smdl_in_if import smdl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] stem_left;
  logic signed [SAMPLE_BITS-1:0] stem_right;
  modport source(output valid, stem_left, stem_right, input ready);
  modport sink(input valid, stem_left, stem_right, output ready);
endinterface

>>> rtl/core/smdl_out_if.sv
// output stream interface: one processed stem item
interface smdl_out_if import smdl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    stem_number;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          frame_last;
  modport source(output valid, stem_number, out_left, out_right, frame_last, input ready);
  modport sink(input valid, stem_number, out_left, out_right, frame_last, output ready);
endinterface

>>> rtl/core/smdl_front.sv
// front end: accepts stem items and tags the last stem of each frame
module smdl_front import smdl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  smdl_in_if.sink    in_s,
  output logic       push_valid_o,
  output item_t      push_item_o,
  input  logic       push_ready_i
);
  logic [K_W-1:0] pos_q;
  logic           last;

  assign last         = (pos_q == K_W'(STEMS - 1));
  assign in_s.ready   = push_ready_i;
  assign push_valid_o = in_s.valid;
  assign push_item_o  = '{left: in_s.stem_left, right: in_s.stem_right, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_s.valid && push_ready_i) begin
      pos_q <= last ? '0 : pos_q + K_W'(1);
    end
  end
endmodule

>>> rtl/core/smdl_queue.sv
// short item queue between front and back
module smdl_queue import smdl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);
  item_t           mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_q, rd_q;
  logic [QP_W:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (QP_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QP_W'(1);
      if (pop)  rd_q <= rd_q + QP_W'(1);
      if (push && !pop) cnt_q <= cnt_q + (QP_W+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (QP_W+1)'(1);
    end
  end
endmodule

>>> rtl/core/smdl_mul.sv
// shared scaler: floor(a * g / 2^16 or 2^32) from two 32-bit partial products
module smdl_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] a_i,
  input  logic [31:0] g_i,
  input  logic        sh32_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_SUM  = 4'b1000
  } mul_state_e;

  mul_state_e  state_q;
  logic [62:0] a_q;
  logic [31:0] g_q;
  logic        sh_q;
  logic [63:0] lo_q;
  logic [62:0] hi_q;
  logic [95:0] sum;
  logic [95:0] shifted;
  logic [63:0] res_q;
  logic        done_q;

  assign sum     = {1'b0, hi_q, 32'b0} + {32'b0, lo_q};
  assign shifted = sh_q ? (sum >> 32) : (sum >> 16);
  assign done_o  = done_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      a_q  <= a_i;
      g_q  <= g_i;
      sh_q <= sh32_i;
    end
    if (state_q == M_LO) lo_q <= 64'(a_q[31:0]) * 64'(g_q);
    if (state_q == M_HI) hi_q <= 63'(a_q[62:32]) * 63'(g_q);
    if (state_q == M_SUM) res_q <= shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == M_SUM);
      unique case (state_q)
        M_IDLE: if (start_i) state_q <= M_LO;
        M_LO:   state_q <= M_HI;
        M_HI:   state_q <= M_SUM;
        M_SUM:  state_q <= M_IDLE;
        default: state_q <= M_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/smdl_div.sv
// radix-2 divider, 32 quotient bits, one bit per cycle; needs num < den * 2^32
module smdl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } div_state_e;

  div_state_e  state_q;
  logic [63:0] rem_q, den_q;
  logic [31:0] low_q, quo_q;
  logic [4:0]  cnt_q;
  logic        done_q;
  logic [64:0] trial;
  logic        fits;

  assign trial  = {rem_q, low_q[31]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      rem_q <= {32'b0, num_i[63:32]};
      low_q <= num_i[31:0];
      den_q <= den_i;
    end else if (state_q == D_RUN) begin
      rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      low_q <= {low_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: if (start_i) begin
          state_q <= D_RUN;
          cnt_q   <= 5'd31;
        end
        D_RUN: begin
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= D_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/smdl_back.sv
// back end: dc blockers, glue envelope, knee gains and stem output sequencer
module smdl_back import smdl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_ready_o,
  smdl_out_if.source out_s
);
  typedef enum logic [18:0] {
    B_IDLE = 19'h00001, B_DCS = 19'h00002, B_DCW = 19'h00004, B_MXS = 19'h00008,
    B_MXW  = 19'h00010, B_ENV = 19'h00020, B_STG = 19'h00040, B_SDS = 19'h00080,
    B_SDW  = 19'h00100, B_SGS = 19'h00200, B_SGW = 19'h00400, B_SGD = 19'h00800,
    B_O1   = 19'h01000, B_O1W = 19'h02000, B_O2  = 19'h04000, B_O2W = 19'h08000,
    B_O3   = 19'h10000, B_O3W = 19'h20000, B_EMIT = 19'h40000
  } back_state_e;

  back_state_e state_q;
  logic [K_W-1:0] k_q;
  logic           side_q, last_q;

  logic signed [SAMPLE_BITS-1:0] x_q [2];
  logic signed [SAMPLE_BITS-1:0] prev_in_q [STEMS][2];
  logic signed [63:0]            prev_out_q [STEMS][2];
  logic signed [MIX_W-1:0]       acc_q [2];
  logic signed [MIX_W-1:0]       mix_in_q [2];
  logic signed [63:0]            mix_out_q [2];
  logic signed [63:0]            bus_q [2];
  logic [31:0] glue_q, stage_q;
  logic [31:0] gain_q [2];
  logic [1:0]  lim_q;
  logic [63:0] val_q, num_q;
  logic signed [SAMPLE_BITS-1:0] res_q [2];

  logic        out_valid_q, out_last_q;
  logic [2:0]  out_num_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;

  logic        mul_start, mul_sh32, mul_done;
  logic [62:0] mul_a;
  logic [31:0] mul_g;
  logic [63:0] mul_res;
  logic        div_start, div_done;
  logic [63:0] div_num, div_den;
  logic [31:0] div_quo;

  logic signed [63:0] po_sel, mo_sel;
  logic signed [SAMPLE_BITS-1:0] x_sel, pin_sel;
  logic signed [65:0] res_ext, term_dc, term_mx, diff_dc, diff_mx, bus_sum;
  logic signed [63:0] y_dc, y_mx, bus_base;
  logic signed [MIX_W-1:0] acc_base;
  logic [62:0] d0, d1, dmax, det_wide;
  logic [31:0] det, env_gap, stage_a;
  logic [47:0] env_step;
  logic [31:0] glue_d;
  logic [63:0] m24;
  logic        lim_now, emit_ok, emit, first;
  logic [32:0] gain_sum;
  logic [31:0] gain_new;
  logic [63:0] q_clamp, q_signed;

  smdl_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .g_i(mul_g),
    .sh32_i(mul_sh32), .done_o(mul_done), .res_o(mul_res)
  );

  smdl_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign po_sel  = prev_out_q[k_q][side_q];
  assign mo_sel  = mix_out_q[side_q];
  assign x_sel   = x_q[side_q];
  assign pin_sel = prev_in_q[k_q][side_q];
  assign first   = (k_q == '0);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_g     = '0;
    mul_sh32  = 1'b0;
    unique case (state_q)
      B_DCS: begin
        mul_start = 1'b1;
        mul_a     = mag63(po_sel);
        mul_g     = {16'b0, cfg_i.dc_coefficient};
      end
      B_MXS: begin
        mul_start = 1'b1;
        mul_a     = mag63(mo_sel);
        mul_g     = {16'b0, cfg_i.dc_coefficient};
      end
      B_SGS: begin
        mul_start = 1'b1;
        mul_a     = mag63(mo_sel);
        mul_g     = stage_q;
        mul_sh32  = 1'b1;
      end
      B_O1: begin
        mul_start = 1'b1;
        mul_a     = mag63(po_sel);
        mul_g     = stage_q;
        mul_sh32  = 1'b1;
      end
      B_O2: begin
        mul_start = 1'b1;
        mul_a     = val_q[62:0];
        mul_g     = gain_q[side_q];
        mul_sh32  = 1'b1;
      end
      B_O3: begin
        mul_start = 1'b1;
        mul_a     = 63'(val_q >> 13);
        mul_g     = {16'b0, cfg_i.master_gain};
      end
      default: mul_start = 1'b0;
    endcase
  end

  // dc blocker arithmetic
  assign res_ext  = $signed({2'b00, mul_res});
  assign term_dc  = po_sel[63] ? -res_ext : res_ext;
  assign term_mx  = mo_sel[63] ? -res_ext : res_ext;
  assign diff_dc  = (66'(x_sel) - 66'(pin_sel)) <<< 16;
  assign diff_mx  = (66'(acc_q[side_q]) - 66'(mix_in_q[side_q])) <<< 16;
  assign y_dc     = sat62(diff_dc + term_dc);
  assign y_mx     = sat62(diff_mx + term_mx);
  assign acc_base = first ? '0 : acc_q[side_q];
  assign bus_base = first ? '0 : bus_q[side_q];
  assign bus_sum  = 66'(bus_base) + 66'(y_dc);

  // glue envelope
  assign d0       = mag63(cfg_i.multichannel_mode ? bus_q[0] : mix_out_q[0]);
  assign d1       = mag63(cfg_i.multichannel_mode ? bus_q[1] : mix_out_q[1]);
  assign dmax     = (d0 > d1) ? d0 : d1;
  assign det_wide = dmax >> Q24_SHIFT;
  assign det      = (|det_wide[62:32]) ? 32'hFFFF_FFFF : det_wide[31:0];
  assign env_gap  = (glue_q < det) ? (det - glue_q) : (glue_q - det);
  assign env_step = 48'(env_gap) * 48'((glue_q < det) ? cfg_i.attack_rate
                                                      : cfg_i.release_rate);
  assign glue_d   = (glue_q < det) ? glue_q + env_step[47:16] : glue_q - env_step[47:16];
  assign stage_a  = GLUE_THRESHOLD + ((glue_q - GLUE_THRESHOLD) >> 1);

  // knee gains
  assign m24      = mul_res >> Q24_SHIFT;
  assign lim_now  = (m24 > KNEE_POINT);
  assign gain_sum = {1'b0, KNEE_SLOPE} + {1'b0, div_quo};
  assign gain_new = gain_sum[32] ? 32'hFFFF_FFFF : gain_sum[31:0];

  assign div_start = (state_q == B_SDS) || (state_q == B_SGW && mul_done && lim_now);
  assign div_num   = (state_q == B_SDS) ? num_q : KNEE_NUM;
  assign div_den   = (state_q == B_SDS) ? {32'b0, glue_q} : m24;

  // output stage
  assign q_clamp  = (mul_res > OUT_LIMIT) ? OUT_LIMIT : mul_res;
  assign q_signed = po_sel[63] ? -q_clamp : q_clamp;
  assign emit_ok  = !out_valid_q || out_s.ready;
  assign emit     = (state_q == B_EMIT) && emit_ok;

  assign q_ready_o         = (state_q == B_IDLE);
  assign out_s.valid       = out_valid_q;
  assign out_s.stem_number = out_num_q;
  assign out_s.out_left    = out_l_q;
  assign out_s.out_right   = out_r_q;
  assign out_s.frame_last  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      side_q      <= 1'b0;
      last_q      <= 1'b0;
      glue_q      <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STEMS; i++) begin
        for (int s = 0; s < 2; s++) begin
          prev_in_q[i][s]  <= '0;
          prev_out_q[i][s] <= '0;
        end
      end
      for (int s = 0; s < 2; s++) begin
        mix_in_q[s]  <= '0;
        mix_out_q[s] <= '0;
      end
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (out_s.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: if (q_valid_i) begin
          x_q[0]  <= q_item_i.left;
          x_q[1]  <= q_item_i.right;
          last_q  <= q_item_i.last;
          side_q  <= 1'b0;
          state_q <= B_DCS;
        end
        B_DCS: state_q <= B_DCW;
        B_DCW: if (mul_done) begin
          prev_in_q[k_q][side_q]  <= x_sel;
          prev_out_q[k_q][side_q] <= y_dc;
          acc_q[side_q]           <= acc_base + MIX_W'(x_sel);
          bus_q[side_q]           <= sat62(bus_sum);
          if (!side_q) begin
            side_q  <= 1'b1;
            state_q <= B_DCS;
          end else if (last_q) begin
            side_q  <= 1'b0;
            state_q <= B_MXS;
          end else begin
            k_q     <= k_q + K_W'(1);
            state_q <= B_IDLE;
          end
        end
        B_MXS: state_q <= B_MXW;
        B_MXW: if (mul_done) begin
          mix_in_q[side_q]  <= acc_q[side_q];
          mix_out_q[side_q] <= y_mx;
          side_q            <= ~side_q;
          state_q           <= side_q ? B_ENV : B_MXS;
        end
        B_ENV: begin
          glue_q  <= glue_d;
          state_q <= B_STG;
        end
        B_STG: begin
          if (glue_q > GLUE_THRESHOLD) begin
            num_q   <= 64'(stage_a) * 64'(STAGE_GAIN);
            state_q <= B_SDS;
          end else begin
            stage_q <= STAGE_GAIN;
            state_q <= B_SGS;
          end
        end
        B_SDS: state_q <= B_SDW;
        B_SDW: if (div_done) begin
          stage_q <= div_quo;
          state_q <= B_SGS;
        end
        B_SGS: state_q <= B_SGW;
        B_SGW: if (mul_done) begin
          lim_q[side_q] <= lim_now;
          if (lim_now) begin
            state_q <= B_SGD;
          end else begin
            side_q  <= ~side_q;
            state_q <= side_q ? B_O1 : B_SGS;
            if (side_q) k_q <= '0;
          end
        end
        B_SGD: if (div_done) begin
          gain_q[side_q] <= gain_new;
          side_q         <= ~side_q;
          state_q        <= side_q ? B_O1 : B_SGS;
          if (side_q) k_q <= '0;
        end
        B_O1: state_q <= B_O1W;
        B_O1W: if (mul_done) begin
          val_q   <= mul_res;
          state_q <= lim_q[side_q] ? B_O2 : B_O3;
        end
        B_O2: state_q <= B_O2W;
        B_O2W: if (mul_done) begin
          val_q   <= mul_res;
          state_q <= B_O3;
        end
        B_O3: state_q <= B_O3W;
        B_O3W: if (mul_done) begin
          res_q[side_q] <= q_signed[SAMPLE_BITS-1:0];
          side_q        <= ~side_q;
          state_q       <= side_q ? B_EMIT : B_O1;
        end
        B_EMIT: if (emit_ok) begin
          out_num_q   <= 3'(k_q);
          out_l_q     <= res_q[0];
          out_r_q     <= res_q[1];
          out_last_q  <= (k_q == K_W'(STEMS - 1));
          if (k_q == K_W'(STEMS - 1)) begin
            k_q     <= '0;
            state_q <= B_IDLE;
          end else begin
            k_q     <= k_q + K_W'(1);
            state_q <= B_O1;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/stem_mix_dc_block_glue_limiter.sv
// top level: stem mix dc blocker, glue compressor and soft limiter
// each stem item needs two dc products (left and right) on the shared scaler in the back end
// after the last stem of a frame the back end runs the mix blocking, the stage gain divider
// when the glue envelope is above threshold, the two knee gains, then the stem results in turn
// a 4-item queue lets the front accept items meanwhile; reset is asynchronous, clears the
// control state and filter history and loads the configuration defaults
module stem_mix_dc_block_glue_limiter import smdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  smdl_in_if.sink     in_s,
  smdl_out_if.source  out_s,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dc_coefficient: 16'd65493, attack_rate: 16'd455, release_rate: 16'd68,
                 master_gain: 16'd9830, multichannel_mode: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DC_COEF: cfg_q.dc_coefficient    <= cfg_data_i;
        CFG_ATTACK:  cfg_q.attack_rate       <= cfg_data_i;
        CFG_RELEASE: cfg_q.release_rate      <= cfg_data_i;
        CFG_MASTER:  cfg_q.master_gain       <= cfg_data_i;
        CFG_MULTI:   cfg_q.multichannel_mode <= cfg_data_i[0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  smdl_front u_front (
    .clk_i, .rst_ni, .in_s,
    .push_valid_o(push_valid), .push_item_o(push_item), .push_ready_i(push_ready)
  );

  smdl_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_item_i(push_item), .push_ready_o(push_ready),
    .pop_valid_o(pop_valid), .pop_item_o(pop_item), .pop_ready_i(pop_ready)
  );

  smdl_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(pop_valid), .q_item_i(pop_item), .q_ready_o(pop_ready),
    .out_s
  );
endmodule

>>> rtl/core/smdl_chk.sv
// port checker for the stem mix output stage, bound to the top level
`include "stem_mix_dc_block_glue_limiter_defines.svh"

module smdl_chk import smdl_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [2:0]                    stem_number_i,
  input logic signed [SAMPLE_BITS-1:0] out_left_i,
  input logic signed [SAMPLE_BITS-1:0] out_right_i,
  input logic                          frame_last_i
);
  `SMDL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `SMDL_ASSERT_IMP(a_last_tag, out_valid_i, frame_last_i == (stem_number_i == 3'(STEMS - 1)))
  `SMDL_ASSERT_IMP(a_left_clamp, out_valid_i, out_left_i <= OUT_LIM_S && out_left_i >= -OUT_LIM_S)
  `SMDL_ASSERT_IMP(a_right_clamp, out_valid_i, out_right_i <= OUT_LIM_S && out_right_i >= -OUT_LIM_S)
endmodule

bind stem_mix_dc_block_glue_limiter smdl_chk u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_i(out_s.valid),
  .out_ready_i(out_s.ready),
  .stem_number_i(out_s.stem_number),
  .out_left_i(out_s.out_left),
  .out_right_i(out_s.out_right),
  .frame_last_i(out_s.frame_last)
);

>>> sim/stem_mix_dc_block_glue_limiter_tb.sv
// testbench for the stem mix output stage: directed and random frames checked against a frame predictor
module stem_mix_dc_block_glue_limiter_tb;
  import smdl_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stem_item_t;

  typedef struct {
    logic [2:0]                    stem_number;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          frame_last;
  } stem_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  smdl_in_if  in_if ();
  smdl_out_if out_if ();

  stem_mix_dc_block_glue_limiter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  stem_item_t   pending_stems[$];
  stem_result_t expected_stems[$];
  bit           failed;
  int unsigned  cycle_count;
  int unsigned  send_gap;
  int unsigned  recv_stall;

  // predictor copy of registers and state
  cfg_t    shadow_cfg;
  longint  frame_l[STEMS], frame_r[STEMS];
  longint  stem_in_l[STEMS], stem_in_r[STEMS], stem_out_l[STEMS], stem_out_r[STEMS];
  longint  mix_in[2], mix_out[2];
  longint unsigned glue_env;
  int      fill_count;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp62(logic signed [65:0] v);
    logic signed [65:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[63:0];
  endfunction

  function automatic longint apply_gain(longint v, longint unsigned g, int sh);
    longint unsigned m, lo, r;
    m  = mag(v);
    lo = m & ((64'd1 << sh) - 64'd1);
    r  = (m >> sh) * g + ((lo * g) >> sh);
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint dc_step(longint x, ref longint prev_in, ref longint prev_out);
    logic signed [65:0] t;
    longint y;
    t = 66'(x - prev_in) * 66'sd65536;
    t = t + 66'(apply_gain(prev_out, shadow_cfg.dc_coefficient, 16));
    y = clamp62(t);
    prev_in  = x;
    prev_out = y;
    return y;
  endfunction

  function automatic longint unsigned knee_gain(longint v, output bit limited);
    longint unsigned m, g;
    m = mag(v) >> Q24_SHIFT;
    limited = m > KNEE_POINT;
    if (!limited) return 0;
    g = longint'(KNEE_SLOPE) + KNEE_NUM / m;
    return g > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : g;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] master_out(longint v);
    longint unsigned q;
    q = ((mag(v) >> 13) * shadow_cfg.master_gain) >> 16;
    if (q > OUT_LIMIT) q = OUT_LIMIT;
    return v < 0 ? SAMPLE_BITS'(-longint'(q)) : SAMPLE_BITS'(q);
  endfunction

  task automatic predict_stem(stem_item_t it);
    longint mix[2], bus_l, bus_r, sl[STEMS], sr[STEMS], a, b, l, r;
    longint unsigned det, stage, gl, gr;
    bit lim_l, lim_r;
    stem_result_t res;
    frame_l[fill_count] = it.left;
    frame_r[fill_count] = it.right;
    fill_count++;
    if (fill_count < STEMS) return;
    fill_count = 0;
    mix[0] = 0;
    mix[1] = 0;
    for (int k = 0; k < STEMS; k++) begin
      mix[0] += frame_l[k];
      mix[1] += frame_r[k];
    end
    mix[0] = dc_step(mix[0], mix_in[0], mix_out[0]);
    mix[1] = dc_step(mix[1], mix_in[1], mix_out[1]);
    bus_l = 0;
    bus_r = 0;
    for (int k = 0; k < STEMS; k++) begin
      sl[k] = dc_step(frame_l[k], stem_in_l[k], stem_out_l[k]);
      sr[k] = dc_step(frame_r[k], stem_in_r[k], stem_out_r[k]);
      bus_l = clamp62(66'(bus_l) + 66'(sl[k]));
      bus_r = clamp62(66'(bus_r) + 66'(sr[k]));
    end
    a = shadow_cfg.multichannel_mode ? bus_l : mix[0];
    b = shadow_cfg.multichannel_mode ? bus_r : mix[1];
    det = (mag(a) > mag(b) ? mag(a) : mag(b)) >> Q24_SHIFT;
    if (det > 64'hFFFF_FFFF) det = 64'hFFFF_FFFF;
    if (glue_env < det) glue_env += ((det - glue_env) * shadow_cfg.attack_rate) >> 16;
    else glue_env -= ((glue_env - det) * shadow_cfg.release_rate) >> 16;
    glue_env &= 64'hFFFF_FFFF;
    if (glue_env > GLUE_THRESHOLD)
      stage = ((longint'(GLUE_THRESHOLD) + ((glue_env - GLUE_THRESHOLD) >> 1))
               * longint'(STAGE_GAIN)) / glue_env;
    else
      stage = STAGE_GAIN;
    gl = knee_gain(apply_gain(mix[0], stage, 32), lim_l);
    gr = knee_gain(apply_gain(mix[1], stage, 32), lim_r);
    for (int k = 0; k < STEMS; k++) begin
      l = apply_gain(sl[k], stage, 32);
      r = apply_gain(sr[k], stage, 32);
      if (lim_l) l = apply_gain(l, gl, 32);
      if (lim_r) r = apply_gain(r, gr, 32);
      res.stem_number = 3'(k);
      res.out_left    = master_out(l);
      res.out_right   = master_out(r);
      res.frame_last  = (k == STEMS - 1);
      expected_stems.push_back(res);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stem item driver
  always @(posedge clk_i or negedge rst_ni) begin
    stem_item_t it;
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.stem_left  <= '0;
      in_if.stem_right <= '0;
      send_gap         <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        it.left  = in_if.stem_left;
        it.right = in_if.stem_right;
        predict_stem(it);
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_stems.size() > 0) begin
          it = pending_stems.pop_front();
          in_if.stem_left  <= it.left;
          in_if.stem_right <= it.right;
          in_if.valid      <= 1'b1;
          send_gap         <= pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    stem_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_stems.size() == 0) begin
          $display("%0t: unexpected item stem %0d left %0d right %0d", $time,
                   out_if.stem_number, out_if.out_left, out_if.out_right);
          failed = 1'b1;
        end else begin
          want = expected_stems.pop_front();
          if (out_if.stem_number !== want.stem_number) begin
            $display("%0t: stem_number expected %0d actual %0d", $time,
                     want.stem_number, out_if.stem_number);
            failed = 1'b1;
          end
          if (out_if.out_left !== want.out_left) begin
            $display("%0t: out_left expected %0d actual %0d", $time,
                     want.out_left, out_if.out_left);
            failed = 1'b1;
          end
          if (out_if.out_right !== want.out_right) begin
            $display("%0t: out_right expected %0d actual %0d", $time,
                     want.out_right, out_if.out_right);
            failed = 1'b1;
          end
          if (out_if.frame_last !== want.frame_last) begin
            $display("%0t: frame_last expected %0d actual %0d", $time,
                     want.frame_last, out_if.frame_last);
            failed = 1'b1;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall   <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) recv_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DC_COEF: shadow_cfg.dc_coefficient    = val;
      CFG_ATTACK:  shadow_cfg.attack_rate       = val;
      CFG_RELEASE: shadow_cfg.release_rate      = val;
      CFG_MASTER:  shadow_cfg.master_gain       = val;
      CFG_MULTI:   shadow_cfg.multichannel_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic add_stem(longint l, longint r);
    stem_item_t it;
    it.left  = SAMPLE_BITS'(l);
    it.right = SAMPLE_BITS'(r);
    pending_stems.push_back(it);
  endtask

  function automatic longint rand_sample();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 4) return longint'($signed(SAMPLE_BITS'($urandom)));
    if (p < 7) return $urandom_range(0, 1) ? 8388607 - $urandom_range(0, 300000)
                                          : -8388608 + $urandom_range(0, 300000);
    return longint'($urandom_range(0, 8000)) - 4000;
  endfunction

  task automatic add_random_frames(int frames);
    longint bias;
    for (int f = 0; f < frames; f++) begin
      bias = $urandom_range(0, 3) == 0 ? rand_sample() : 0;
      for (int k = 0; k < STEMS; k++) begin
        if (bias != 0) add_stem(bias, -bias);
        else add_stem(rand_sample(), rand_sample());
      end
    end
  endtask

  task automatic drain();
    while (pending_stems.size() > 0 || in_if.valid || expected_stems.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    failed      = 1'b0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DC_COEF;
    cfg_data_i  = '0;
    shadow_cfg  = '{dc_coefficient: 16'd65493, attack_rate: 16'd455, release_rate: 16'd68,
                    master_gain: 16'd9830, multichannel_mode: 1'b0};
    for (int k = 0; k < STEMS; k++) begin
      stem_in_l[k]  = 0;
      stem_in_r[k]  = 0;
      stem_out_l[k] = 0;
      stem_out_r[k] = 0;
    end
    mix_in     = '{0, 0};
    mix_out    = '{0, 0};
    glue_env   = 0;
    fill_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full scale, opposite extremes, alternating extremes
    for (int k = 0; k < STEMS; k++) add_stem(8388607, -8388608);
    for (int k = 0; k < STEMS; k++) add_stem(-8388608, 8388607);
    for (int k = 0; k < STEMS; k++) add_stem(k[0] ? 8388607 : -8388608, 0);
    add_random_frames(7);
    drain();

    write_reg(CFG_DC_COEF, 16'd0);
    write_reg(CFG_ATTACK, 16'hFFFF);
    write_reg(CFG_RELEASE, 16'hFFFF);
    write_reg(CFG_MASTER, 16'hFFFF);
    write_reg(CFG_MULTI, 16'd1);
    write_reg(3'd5, 16'h1234);
    for (int k = 0; k < STEMS; k++) add_stem(8388607, 8388607);
    add_random_frames(9);
    drain();

    write_reg(CFG_DC_COEF, 16'hFFFF);
    write_reg(CFG_ATTACK, 16'd1);
    write_reg(CFG_RELEASE, 16'd1);
    write_reg(CFG_MASTER, 16'd0);
    write_reg(CFG_MULTI, 16'd0);
    add_random_frames(6);
    drain();

    write_reg(CFG_DC_COEF, 16'($urandom));
    write_reg(CFG_ATTACK, 16'd0);
    write_reg(CFG_RELEASE, 16'($urandom_range(1, 65535)));
    write_reg(CFG_MASTER, 16'($urandom));
    write_reg(CFG_MULTI, 16'd1);
    write_reg(3'd7, 16'hFFFF);
    add_random_frames(10);
    drain();

    write_reg(CFG_DC_COEF, 16'd65493);
    write_reg(CFG_ATTACK, 16'($urandom_range(1, 65535)));
    write_reg(CFG_RELEASE, 16'd0);
    write_reg(CFG_MASTER, 16'($urandom_range(8192, 65535)));
    write_reg(CFG_MULTI, 16'd0);
    add_random_frames(10);
    drain();

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/smdl_pkg.sv
rtl/core/smdl_in_if.sv
rtl/core/smdl_out_if.sv
rtl/core/smdl_front.sv
rtl/core/smdl_queue.sv
rtl/core/smdl_mul.sv
rtl/core/smdl_div.sv
rtl/core/smdl_back.sv
rtl/core/stem_mix_dc_block_glue_limiter.sv
rtl/core/smdl_chk.sv
sim/stem_mix_dc_block_glue_limiter_tb.sv
